// ===== src/tfr_pkg.sv =====
package tfr_pkg;

	localparam logic [7:0] FRAME_START = 8'h06;
	localparam logic [7:0] FRAME_STOP  = 8'h07;
	localparam logic [7:0] CMD_RPM     = 8'd1;
	localparam logic [7:0] CMD_CURRENT = 8'd2;
	localparam logic [7:0] LEN_ONE     = 8'd1;
	localparam logic [7:0] LEN_TWO     = 8'd2;

	localparam int EVQ_DEPTH  = 4;
	localparam int EVQ_AW     = $clog2(EVQ_DEPTH);
	localparam int OUTQ_DEPTH = 2;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LEN,
		PH_CMD,
		PH_PAYLOAD,
		PH_CHECK,
		PH_STOP
	} phase_t;

	// What the parser reports for one received byte.
	typedef struct packed {
		logic        done;
		logic        err;
		logic [7:0]  cmd;
		logic [15:0] value;
	} event_t;

	typedef struct packed {
		logic        frame_done;
		logic        frame_error;
		logic [7:0]  frame_command;
		logic [15:0] frame_value;
		logic [15:0] rpm_now;
		logic [15:0] rpm_low;
		logic [15:0] rpm_high;
		logic [15:0] motor_current;
	} result_t;

endpackage

// ===== src/tfr_front.sv =====
module tfr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          rx_byte,
	output tfr_pkg::event_t     ev
);

	tfr_pkg::phase_t phase_q, phase_next;
	logic [1:0]  len_q;
	logic [1:0]  cnt_q;
	logic [1:0]  cnt_inc;
	logic [7:0]  cmd_q;
	logic [15:0] acc_q;
	logic [7:0]  xor_q;
	logic        chk_q;
	logic        len_good;

	assign len_good = (rx_byte == tfr_pkg::LEN_ONE) || (rx_byte == tfr_pkg::LEN_TWO);
	assign cnt_inc  = cnt_q + 2'd1;

	always_comb begin
		phase_next = phase_q;
		unique case (phase_q)
			tfr_pkg::PH_HUNT: begin
				if (rx_byte == tfr_pkg::FRAME_START) phase_next = tfr_pkg::PH_LEN;
			end
			tfr_pkg::PH_LEN: begin
				phase_next = len_good ? tfr_pkg::PH_CMD : tfr_pkg::PH_HUNT;
			end
			tfr_pkg::PH_CMD:     phase_next = tfr_pkg::PH_PAYLOAD;
			tfr_pkg::PH_PAYLOAD: begin
				if (cnt_inc >= len_q) phase_next = tfr_pkg::PH_CHECK;
			end
			tfr_pkg::PH_CHECK:   phase_next = tfr_pkg::PH_STOP;
			tfr_pkg::PH_STOP:    phase_next = tfr_pkg::PH_HUNT;
			default:             phase_next = tfr_pkg::PH_HUNT;
		endcase
	end

	always_comb begin
		ev.done  = 1'b0;
		ev.err   = 1'b0;
		ev.cmd   = cmd_q;
		ev.value = acc_q;
		unique case (phase_q)
			tfr_pkg::PH_LEN: ev.err = !len_good;
			tfr_pkg::PH_STOP: begin
				ev.done = (rx_byte == tfr_pkg::FRAME_STOP) && chk_q;
				ev.err  = !((rx_byte == tfr_pkg::FRAME_STOP) && chk_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tfr_pkg::PH_HUNT;
		end else if (take) begin
			phase_q <= phase_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			cnt_q <= '0;
			cmd_q <= '0;
			acc_q <= '0;
			xor_q <= '0;
			chk_q <= 1'b0;
		end else if (take) begin
			unique case (phase_q)
				tfr_pkg::PH_HUNT: begin
					if (rx_byte == tfr_pkg::FRAME_START) begin
						xor_q <= tfr_pkg::FRAME_START;
						chk_q <= 1'b0;
					end
				end
				tfr_pkg::PH_LEN: begin
					if (len_good) begin
						len_q <= rx_byte[1:0];
						xor_q <= xor_q ^ rx_byte;
					end
				end
				tfr_pkg::PH_CMD: begin
					cmd_q <= rx_byte;
					xor_q <= xor_q ^ rx_byte;
					cnt_q <= '0;
					acc_q <= '0;
				end
				tfr_pkg::PH_PAYLOAD: begin
					acc_q <= {acc_q[7:0], rx_byte};
					xor_q <= xor_q ^ rx_byte;
					cnt_q <= cnt_inc;
				end
				tfr_pkg::PH_CHECK: chk_q <= (rx_byte == xor_q);
				default: ;
			endcase
		end
	end

	a_done_err_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ev.done && ev.err)) else $error("done and error on the same byte");
	a_done_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		(take && ev.done) |-> $past(phase_q == tfr_pkg::PH_CHECK || !take))
		else $error("frame completed without a check byte before it");

endmodule

// ===== src/tfr_evq.sv =====
module tfr_evq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  tfr_pkg::event_t wr_data,
	output logic            full,
	input  logic            rd,
	output logic            avail,
	output tfr_pkg::event_t rd_data
);

	tfr_pkg::event_t             mem_q [tfr_pkg::EVQ_DEPTH];
	logic [tfr_pkg::EVQ_AW-1:0]  wptr_q, rptr_q;
	logic [tfr_pkg::EVQ_AW:0]    cnt_q;
	logic                        do_wr, do_rd;

	assign full    = (cnt_q == (tfr_pkg::EVQ_AW+1)'(tfr_pkg::EVQ_DEPTH));
	assign avail   = (cnt_q != '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && avail;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) wptr_q <= wptr_q + 1'b1;
			if (do_rd) rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + (tfr_pkg::EVQ_AW+1)'(do_wr) - (tfr_pkg::EVQ_AW+1)'(do_rd);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (tfr_pkg::EVQ_AW+1)'(tfr_pkg::EVQ_DEPTH))
		else $error("event queue overflow");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wptr_q - rptr_q) == cnt_q[tfr_pkg::EVQ_AW-1:0])
		else $error("event queue pointers disagree with count");

endmodule

// ===== src/tfr_back.sv =====
module tfr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ev_avail,
	input  tfr_pkg::event_t  ev,
	output logic             ev_take,
	input  logic             pop,
	output logic             empty,
	output tfr_pkg::result_t res
);

	logic [7:0]  last_cmd_q;
	logic [15:0] last_val_q;
	logic        seen_q;
	logic [15:0] now_q, low_q, high_q, cur_q;

	logic [7:0]  last_cmd_d;
	logic [15:0] last_val_d;
	logic        seen_d;
	logic [15:0] now_d, low_d, high_d, cur_d;

	tfr_pkg::result_t            outq_q [tfr_pkg::OUTQ_DEPTH];
	logic [tfr_pkg::OUTQ_AW-1:0] wptr_q, rptr_q;
	logic [tfr_pkg::OUTQ_AW:0]   ocnt_q;
	logic                        ofull, do_pop;
	tfr_pkg::result_t            res_d;

	assign ofull   = (ocnt_q == (tfr_pkg::OUTQ_AW+1)'(tfr_pkg::OUTQ_DEPTH));
	assign empty   = (ocnt_q == '0);
	assign ev_take = ev_avail && !ofull;
	assign do_pop  = pop && !empty;
	assign res     = outq_q[rptr_q];

	always_comb begin
		last_cmd_d = last_cmd_q;
		last_val_d = last_val_q;
		seen_d     = seen_q;
		now_d      = now_q;
		low_d      = low_q;
		high_d     = high_q;
		cur_d      = cur_q;
		if (ev.done) begin
			last_cmd_d = ev.cmd;
			last_val_d = ev.value;
			if (ev.cmd == tfr_pkg::CMD_RPM) begin
				// The first sample only seeds the minimum.
				if (!seen_q) begin
					low_d  = ev.value;
					seen_d = 1'b1;
				end else begin
					if (ev.value < low_q)  low_d  = ev.value;
					if (ev.value > high_q) high_d = ev.value;
					now_d = ev.value;
				end
			end else if (ev.cmd == tfr_pkg::CMD_CURRENT) begin
				cur_d = ev.value;
			end
		end
		res_d.frame_done    = ev.done;
		res_d.frame_error   = ev.err;
		res_d.frame_command = last_cmd_d;
		res_d.frame_value   = last_val_d;
		res_d.rpm_now       = now_d;
		res_d.rpm_low       = low_d;
		res_d.rpm_high      = high_d;
		res_d.motor_current = cur_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cmd_q <= '0;
			last_val_q <= '0;
			seen_q     <= 1'b0;
			now_q      <= '0;
			low_q      <= '0;
			high_q     <= '0;
			cur_q      <= '0;
		end else if (ev_take) begin
			last_cmd_q <= last_cmd_d;
			last_val_q <= last_val_d;
			seen_q     <= seen_d;
			now_q      <= now_d;
			low_q      <= low_d;
			high_q     <= high_d;
			cur_q      <= cur_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_take) outq_q[wptr_q] <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			ocnt_q <= '0;
		end else begin
			if (ev_take) wptr_q <= wptr_q + 1'b1;
			if (do_pop)  rptr_q <= rptr_q + 1'b1;
			ocnt_q <= ocnt_q + (tfr_pkg::OUTQ_AW+1)'(ev_take)
				- (tfr_pkg::OUTQ_AW+1)'(do_pop);
		end
	end

	a_outq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= (tfr_pkg::OUTQ_AW+1)'(tfr_pkg::OUTQ_DEPTH))
		else $error("result queue overflow");
	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(seen_q) |-> seen_q) else $error("first RPM sample flag cleared");

endmodule

// ===== src/telemetry_frame_receiver_top.sv =====
// Channel   Handshake          Payload
// input     push / full        rx_byte
// result    empty / pop        frame_done, frame_error, frame_command, frame_value,
//                              rpm_now, rpm_low, rpm_high, motor_current
//
// One byte is accepted per cycle while full is low, and each byte yields exactly one result transaction.
// The parser classifies each byte as it is accepted and writes the event into a
// four-entry event queue; the bookkeeping stage takes events from it while the
// two-entry result queue has room and writes one result per event.
// Reset (arst_n low) empties both queues and returns the parser to start-byte hunt.
// When pop stalls, the result queue and then the event queue fill, and full rises.
module telemetry_frame_receiver_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic        frame_done,
	output logic        frame_error,
	output logic [7:0]  frame_command,
	output logic [15:0] frame_value,
	output logic [15:0] rpm_now,
	output logic [15:0] rpm_low,
	output logic [15:0] rpm_high,
	output logic [15:0] motor_current
);

	tfr_pkg::event_t  fr_ev, q_ev;
	tfr_pkg::result_t res;
	logic             take, q_avail, q_take;

	assign take = push && !full;

	tfr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.ev      (fr_ev)
	);

	tfr_evq u_evq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (take),
		.wr_data (fr_ev),
		.full    (full),
		.rd      (q_take),
		.avail   (q_avail),
		.rd_data (q_ev)
	);

	tfr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_avail (q_avail),
		.ev       (q_ev),
		.ev_take  (q_take),
		.pop      (pop),
		.empty    (empty),
		.res      (res)
	);

	assign frame_done    = res.frame_done;
	assign frame_error   = res.frame_error;
	assign frame_command = res.frame_command;
	assign frame_value   = res.frame_value;
	assign rpm_now       = res.rpm_now;
	assign rpm_low       = res.rpm_low;
	assign rpm_high      = res.rpm_high;
	assign motor_current = res.motor_current;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	typedef enum {
		POP_ALWAYS,
		POP_COIN,
		POP_RARE
	} pop_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  rx_byte = 8'h00;
	logic        empty;
	logic        pop = 1'b0;
	logic        frame_done;
	logic        frame_error;
	logic [7:0]  frame_command;
	logic [15:0] frame_value;
	logic [15:0] rpm_now;
	logic [15:0] rpm_low;
	logic [15:0] rpm_high;
	logic [15:0] motor_current;

	// Predicted parser and bookkeeping state.
	tfr_pkg::phase_t pred_phase = tfr_pkg::PH_HUNT;
	logic [1:0]  pred_len = 2'd0;
	logic [1:0]  pred_count = 2'd0;
	logic [7:0]  pred_cmd = 8'h00;
	logic [15:0] pred_acc = 16'h0000;
	logic [7:0]  pred_xor = 8'h00;
	logic        pred_check_good = 1'b0;
	logic        pred_rpm_primed = 1'b0;
	logic [15:0] pred_rpm_now = 16'h0000;
	logic [15:0] pred_rpm_low = 16'h0000;
	logic [15:0] pred_rpm_high = 16'h0000;
	logic [15:0] pred_current = 16'h0000;
	logic [7:0]  pred_last_cmd = 8'h00;
	logic [15:0] pred_last_value = 16'h0000;

	tfr_pkg::result_t pending_results[$];
	int          mismatch_count = 0;
	int          bytes_sent = 0;
	int          burst_left = 0;
	pop_mode_t   pop_mode = POP_ALWAYS;
	int          pop_mode_left = 0;

	telemetry_frame_receiver_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.rx_byte      (rx_byte),
		.empty        (empty),
		.pop          (pop),
		.frame_done   (frame_done),
		.frame_error  (frame_error),
		.frame_command(frame_command),
		.frame_value  (frame_value),
		.rpm_now      (rpm_now),
		.rpm_low      (rpm_low),
		.rpm_high     (rpm_high),
		.motor_current(motor_current)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		mismatch_count++;
		if (mismatch_count <= 200)
			$display("%0t: %s: got %h, want %h", $time, what, got, want);
	endtask

	// Advances the predicted parser by one byte and queues the result it must produce.
	task automatic parse_byte(input logic [7:0] b);
		tfr_pkg::result_t r;
		r = '0;
		case (pred_phase)
			tfr_pkg::PH_HUNT: begin
				if (b == tfr_pkg::FRAME_START) begin
					pred_xor = tfr_pkg::FRAME_START;
					pred_check_good = 1'b0;
					pred_phase = tfr_pkg::PH_LEN;
				end
			end
			tfr_pkg::PH_LEN: begin
				if (b == tfr_pkg::LEN_ONE || b == tfr_pkg::LEN_TWO) begin
					pred_len = b[1:0];
					pred_xor ^= b;
					pred_phase = tfr_pkg::PH_CMD;
				end else begin
					r.frame_error = 1'b1;
					pred_phase = tfr_pkg::PH_HUNT;
				end
			end
			tfr_pkg::PH_CMD: begin
				pred_cmd = b;
				pred_xor ^= b;
				pred_count = 2'd0;
				pred_acc = 16'h0000;
				pred_phase = tfr_pkg::PH_PAYLOAD;
			end
			tfr_pkg::PH_PAYLOAD: begin
				pred_acc = {pred_acc[7:0], b};
				pred_xor ^= b;
				pred_count = pred_count + 2'd1;
				if (pred_count >= pred_len)
					pred_phase = tfr_pkg::PH_CHECK;
			end
			tfr_pkg::PH_CHECK: begin
				pred_check_good = (b == pred_xor);
				pred_phase = tfr_pkg::PH_STOP;
			end
			tfr_pkg::PH_STOP: begin
				if (b == tfr_pkg::FRAME_STOP && pred_check_good) begin
					r.frame_done = 1'b1;
					pred_last_cmd = pred_cmd;
					pred_last_value = pred_acc;
					if (pred_cmd == tfr_pkg::CMD_RPM) begin
						// The first sample only seeds the minimum.
						if (!pred_rpm_primed) begin
							pred_rpm_low = pred_acc;
							pred_rpm_primed = 1'b1;
						end else begin
							if (pred_acc < pred_rpm_low)
								pred_rpm_low = pred_acc;
							if (pred_acc > pred_rpm_high)
								pred_rpm_high = pred_acc;
							pred_rpm_now = pred_acc;
						end
					end else if (pred_cmd == tfr_pkg::CMD_CURRENT) begin
						pred_current = pred_acc;
					end
				end else begin
					r.frame_error = 1'b1;
				end
				pred_phase = tfr_pkg::PH_HUNT;
			end
			default: pred_phase = tfr_pkg::PH_HUNT;
		endcase
		r.frame_command = pred_last_cmd;
		r.frame_value = pred_last_value;
		r.rpm_now = pred_rpm_now;
		r.rpm_low = pred_rpm_low;
		r.rpm_high = pred_rpm_high;
		r.motor_current = pred_current;
		pending_results.push_back(r);
	endtask

	// Called at a falling edge; returns at the falling edge after the byte was taken.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			push <= 1'b0;
			rx_byte <= 8'($urandom_range(0, 255));
			gap = $urandom_range(1, 12);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 8);
		end
		burst_left--;
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		parse_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Sends the first byte_limit bytes of a frame; corrupt flips bits of the check byte.
	task automatic send_frame(input logic [1:0] len, input logic [7:0] cmd,
			input logic [15:0] value, input logic [7:0] corrupt, input logic [7:0] stop_byte,
			input int byte_limit);
		logic [7:0] frame_bytes[$];
		logic [7:0] xsum;
		frame_bytes = {tfr_pkg::FRAME_START, {6'b0, len}, cmd};
		if (len == 2'd2)
			frame_bytes.push_back(value[15:8]);
		frame_bytes.push_back(value[7:0]);
		xsum = 8'h00;
		foreach (frame_bytes[i])
			xsum ^= frame_bytes[i];
		frame_bytes.push_back(xsum ^ corrupt);
		frame_bytes.push_back(stop_byte);
		foreach (frame_bytes[i])
			if (i < byte_limit)
				send_byte(frame_bytes[i]);
	endtask

	task automatic wait_for_results();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_hunt_and_length();
		send_byte(8'hFF);
		// A start byte in the length position is consumed as a bad length.
		send_byte(tfr_pkg::FRAME_START);
		send_byte(tfr_pkg::FRAME_START);
		send_byte(tfr_pkg::FRAME_START);
		send_byte(8'h03);
	endtask

	task automatic test_rpm_frames();
		send_frame(2'd1, tfr_pkg::CMD_RPM, 16'h0080, 8'h00, tfr_pkg::FRAME_STOP, 6);
		send_frame(2'd2, tfr_pkg::CMD_RPM, 16'hFFFF, 8'h00, tfr_pkg::FRAME_STOP, 7);
	endtask

	task automatic test_current_and_other_frames();
		// Start and stop bytes as payload carry no special meaning.
		send_frame(2'd2, tfr_pkg::CMD_CURRENT, 16'h0607, 8'h00, tfr_pkg::FRAME_STOP, 7);
		send_frame(2'd1, 8'hFF, 16'h00A5, 8'h00, tfr_pkg::FRAME_STOP, 6);
	endtask

	task automatic test_broken_frames();
		send_frame(2'd1, 8'h80, 16'h0055, 8'h01, tfr_pkg::FRAME_STOP, 6);
		send_frame(2'd1, tfr_pkg::CMD_RPM, 16'h0012, 8'h00, tfr_pkg::FRAME_START, 6);
	endtask

	task automatic send_random_frame();
		int pick;
		int n;
		logic [1:0] len;
		logic [7:0] cmd;
		logic [15:0] value;
		logic [7:0] corrupt;
		logic [7:0] stop_byte;
		logic [7:0] b;
		int byte_limit;
		pick = $urandom_range(0, 99);
		len = 2'($urandom_range(1, 2));
		n = $urandom_range(0, 99);
		cmd = (n < 45) ? tfr_pkg::CMD_RPM : (n < 80) ? tfr_pkg::CMD_CURRENT
			: 8'($urandom_range(0, 255));
		n = $urandom_range(0, 15);
		value = (n == 0) ? 16'h0000 : (n == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
		corrupt = 8'h00;
		stop_byte = tfr_pkg::FRAME_STOP;
		byte_limit = 5 + len;
		if (pick < 6) begin
			n = $urandom_range(1, 3);
			repeat (n)
				send_byte(8'($urandom_range(0, 255)));
		end else if (pick < 12) begin
			b = 8'($urandom_range(0, 255));
			if (b == tfr_pkg::LEN_ONE || b == tfr_pkg::LEN_TWO)
				b = tfr_pkg::FRAME_START;
			send_byte(tfr_pkg::FRAME_START);
			send_byte(b);
		end else begin
			if (pick < 18) begin
				corrupt = 8'($urandom_range(1, 255));
			end else if (pick < 24) begin
				stop_byte = 8'($urandom_range(0, 255));
				if (stop_byte == tfr_pkg::FRAME_STOP)
					stop_byte = 8'h00;
			end else if (pick < 30) begin
				byte_limit = $urandom_range(1, 4 + len);
			end
			send_frame(len, cmd, value, corrupt, stop_byte, byte_limit);
		end
	endtask

	task automatic test_random_traffic();
		int stop_at;
		int pause_at;
		stop_at = bytes_sent + 500;
		pause_at = bytes_sent + 250;
		while (bytes_sent < stop_at) begin
			send_random_frame();
			if (pause_at != 0 && bytes_sent >= pause_at) begin
				pause_at = 0;
				wait_for_results();
			end
		end
	endtask

	// The receiver runs in stretches of always ready, coin flip, or mostly stalled.
	always @(negedge clk) begin
		if (pop_mode_left == 0) begin
			pop_mode = pop_mode_t'($urandom_range(0, 2));
			pop_mode_left = $urandom_range(5, 60);
		end
		pop_mode_left--;
		case (pop_mode)
			POP_ALWAYS: pop <= 1'b1;
			POP_COIN: pop <= 1'($urandom_range(0, 1));
			default: pop <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin : check_results
		tfr_pkg::result_t got;
		tfr_pkg::result_t want;
		if (arst_n && pop && !empty) begin
			got = {frame_done, frame_error, frame_command, frame_value,
				rpm_now, rpm_low, rpm_high, motor_current};
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", 16'h0, 16'h0);
			end else begin
				want = pending_results.pop_front();
				if (got.frame_done !== want.frame_done)
					report_mismatch("frame_done", 16'(got.frame_done),
						16'(want.frame_done));
				if (got.frame_error !== want.frame_error)
					report_mismatch("frame_error", 16'(got.frame_error),
						16'(want.frame_error));
				if (got.frame_command !== want.frame_command)
					report_mismatch("frame_command", 16'(got.frame_command),
						16'(want.frame_command));
				if (got.frame_value !== want.frame_value)
					report_mismatch("frame_value", got.frame_value, want.frame_value);
				if (got.rpm_now !== want.rpm_now)
					report_mismatch("rpm_now", got.rpm_now, want.rpm_now);
				if (got.rpm_low !== want.rpm_low)
					report_mismatch("rpm_low", got.rpm_low, want.rpm_low);
				if (got.rpm_high !== want.rpm_high)
					report_mismatch("rpm_high", got.rpm_high, want.rpm_high);
				if (got.motor_current !== want.motor_current)
					report_mismatch("motor_current", got.motor_current, want.motor_current);
			end
		end
	end

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_hunt_and_length();
		test_rpm_frames();
		test_current_and_other_frames();
		test_broken_frames();
		test_random_traffic();
		wait_for_results();
		// Anything arriving now has no matching byte and is flagged by the checker.
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
src/tfr_pkg.sv
src/tfr_front.sv
src/tfr_evq.sv
src/tfr_back.sv
src/telemetry_frame_receiver_top.sv
dv/testbench.sv
